@@ rtl/core/karplus_dihedral_coupling_macros.svh @@
// ----------------------------------------------------------------------------
// Karplus dihedral coupling assertion macros
// Shared property forms for the coupling pipeline checks.
// ----------------------------------------------------------------------------
`ifndef KARPLUS_DIHEDRAL_COUPLING_MACROS_SVH
`define KARPLUS_DIHEDRAL_COUPLING_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define KDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define KDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/kdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Karplus dihedral coupling package
// Types, widths, constants and coefficient tables of the coupling pipeline.
// ----------------------------------------------------------------------------
package kdc_pkg;

  localparam int COORD_BITS = 21;
  localparam int PT_W       = 63;
  localparam int DW         = COORD_BITS + 1;
  localparam int NW         = 2 * DW + 1;
  localparam int LW         = $clog2(NW);
  localparam int NORM_MSB   = 14;
  localparam int NPW        = NORM_MSB + 2;
  localparam int PW         = 2 * NPW;
  localparam int SW         = PW + 2;
  localparam int DMAG_W     = SW - 1;
  localparam int SQ_W       = 64;
  localparam int RT_W       = SQ_W / 2;
  localparam int SQ_STEPS   = 2;
  localparam int SQ_STAGES  = RT_W / SQ_STEPS;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = RT_W / DIV_STEPS;
  localparam int LATENCY    = 18 + SQ_STAGES + DIV_STAGES;

  localparam int Q30        = 30;
  localparam int CM_W       = Q30 + 1;
  localparam int CF_W       = 11;
  localparam int PR_W       = CF_W + 32;
  localparam int TW         = PR_W + 1;
  localparam int U_W        = 22;
  localparam int OUT_SHIFT  = 20;
  localparam int OUT_SCALE  = 100;
  localparam int OUT_HALF   = (OUT_SCALE / 2) << OUT_SHIFT;
  localparam int RECIP      = 41944;
  localparam int RECIP_SH   = 22;
  localparam int JM_W       = 16;
  localparam int J_MAX      = 16383;
  localparam int J_MIN_MAG  = 16384;

  localparam logic [1:0] REQ_HN_HA  = 2'd0;
  localparam logic [1:0] REQ_N_CG   = 2'd1;
  localparam logic [1:0] REQ_CP_CG  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0]      req_type;
    logic            atoms_present;
    logic [PT_W-1:0] point_one;
    logic [PT_W-1:0] point_two;
    logic [PT_W-1:0] point_three;
    logic [PT_W-1:0] point_four;
  } kdc_req_t;

  typedef struct packed {
    logic signed [14:0] coupling;
    logic               coupling_valid;
  } kdc_rsp_t;

  typedef struct packed {
    logic              ok;
    logic [1:0]        sel;
    logic              neg;
    logic [DMAG_W-1:0] mag;
  } kdc_tag_t;

  function automatic logic signed [CF_W-1:0] coef_a(input logic [1:0] sel);
    unique case (sel)
      REQ_HN_HA: coef_a = 11'sd651;
      REQ_N_CG:  coef_a = 11'sd129;
      REQ_CP_CG: coef_a = 11'sd174;
      default:   coef_a = '0;
    endcase
  endfunction

  function automatic logic signed [CF_W-1:0] coef_b(input logic [1:0] sel);
    unique case (sel)
      REQ_HN_HA: coef_b = -11'sd176;
      REQ_N_CG:  coef_b = -11'sd49;
      REQ_CP_CG: coef_b = -11'sd57;
      default:   coef_b = '0;
    endcase
  endfunction

  function automatic logic signed [CF_W-1:0] coef_c(input logic [1:0] sel);
    unique case (sel)
      REQ_HN_HA: coef_c = 11'sd160;
      REQ_N_CG:  coef_c = 11'sd37;
      REQ_CP_CG: coef_c = 11'sd25;
      default:   coef_c = '0;
    endcase
  endfunction

  function automatic logic [LW-1:0] lead_pos(input logic [NW-1:0] v);
    lead_pos = '0;
    for (int i = 0; i < NW; i++) begin
      if (v[i]) lead_pos = LW'(i);
    end
  endfunction

endpackage

@@ rtl/core/kdc_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit word, two root bits per register stage.
// ----------------------------------------------------------------------------
module kdc_isqrt (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [kdc_pkg::SQ_W-1:0] x,
  input  kdc_pkg::kdc_tag_t      in_tag,
  output logic                   out_valid,
  output logic [kdc_pkg::RT_W-1:0] root,
  output kdc_pkg::kdc_tag_t      out_tag
);
  import kdc_pkg::*;

  logic [SQ_W-1:0] xs [SQ_STAGES+1];
  logic [RT_W+1:0] rm [SQ_STAGES+1];
  logic [RT_W-1:0] rt [SQ_STAGES+1];
  kdc_tag_t        tg [SQ_STAGES+1];
  logic            vl [SQ_STAGES+1];

  assign xs[0] = x;
  assign rm[0] = '0;
  assign rt[0] = '0;
  assign tg[0] = in_tag;
  assign vl[0] = in_valid;

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic [SQ_W-1:0] xn;
    logic [RT_W+1:0] rn;
    logic [RT_W-1:0] qn;

    always_comb begin
      logic [RT_W+3:0] t;
      logic [RT_W+3:0] trial;
      xn = xs[s];
      rn = rm[s];
      qn = rt[s];
      for (int i = 0; i < SQ_STEPS; i++) begin
        t     = {rn, xn[SQ_W-1 -: 2]};
        trial = {2'b00, qn, 2'b01};
        xn    = {xn[SQ_W-3:0], 2'b00};
        if (t >= trial) begin
          rn = (RT_W+2)'(t - trial);
          qn = {qn[RT_W-2:0], 1'b1};
        end else begin
          rn = t[RT_W+1:0];
          qn = {qn[RT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      xs[s+1] <= xn;
      rm[s+1] <= rn;
      rt[s+1] <= qn;
      tg[s+1] <= tg[s];
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else begin
        vl[s+1] <= vl[s];
      end
    end
  end

  assign out_valid = vl[SQ_STAGES];
  assign root      = rt[SQ_STAGES];
  assign out_tag   = tg[SQ_STAGES];

endmodule

@@ rtl/core/kdc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 64-bit by 32-bit quotient, two quotient bits per register stage; the user
// must keep the upper half of the numerator below the divisor; not enforced.
// ----------------------------------------------------------------------------
module kdc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [kdc_pkg::SQ_W-1:0] num,
  input  logic [kdc_pkg::RT_W-1:0] den,
  input  kdc_pkg::kdc_tag_t        in_tag,
  output logic                     out_valid,
  output logic [kdc_pkg::RT_W-1:0] quo,
  output kdc_pkg::kdc_tag_t        out_tag
);
  import kdc_pkg::*;

  logic [RT_W-1:0] ls [DIV_STAGES+1];
  logic [RT_W-1:0] rm [DIV_STAGES+1];
  logic [RT_W-1:0] qt [DIV_STAGES+1];
  logic [RT_W-1:0] dn [DIV_STAGES+1];
  kdc_tag_t        tg [DIV_STAGES+1];
  logic            vl [DIV_STAGES+1];

  assign ls[0] = num[RT_W-1:0];
  assign rm[0] = num[SQ_W-1:RT_W];
  assign qt[0] = '0;
  assign dn[0] = den;
  assign tg[0] = in_tag;
  assign vl[0] = in_valid;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [RT_W-1:0] ln;
    logic [RT_W-1:0] rn;
    logic [RT_W-1:0] qn;

    always_comb begin
      logic [RT_W:0] t;
      ln = ls[s];
      rn = rm[s];
      qn = qt[s];
      for (int i = 0; i < DIV_STEPS; i++) begin
        t  = {rn, ln[RT_W-1]};
        ln = {ln[RT_W-2:0], 1'b0};
        if (t >= {1'b0, dn[s]}) begin
          rn = RT_W'(t - {1'b0, dn[s]});
          qn = {qn[RT_W-2:0], 1'b1};
        end else begin
          rn = t[RT_W-1:0];
          qn = {qn[RT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      ls[s+1] <= ln;
      rm[s+1] <= rn;
      qt[s+1] <= qn;
      dn[s+1] <= dn[s];
      tg[s+1] <= tg[s];
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else begin
        vl[s+1] <= vl[s];
      end
    end
  end

  assign out_valid = vl[DIV_STAGES];
  assign quo       = qt[DIV_STAGES];
  assign out_tag   = tg[DIV_STAGES];

endmodule

@@ rtl/core/karplus_dihedral_coupling.sv @@
// ----------------------------------------------------------------------------
// Karplus dihedral coupling
// Three-bond coupling from four atom positions over a fixed-point pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req and raise start; the item transfers at each
//   rising edge with start high and busy low. busy stays low, so one item
//   may transfer in every cycle.
//   Result channel: done is high for exactly one cycle with result; the
//   receiver takes it at the edge that ends that cycle and cannot hold it off.
//   Latency is the same for every item, from the transfer edge to the edge
//   that takes the result. Throughput: one item per cycle.
//   The pipeline holds the two 16-stage units, the square root of
//   |n1|^2*|n2|^2 and the Q30 cosine divider, plus 17 arithmetic stages
//   and the output register.
//   Results leave in transfer order. Invalid items (no atoms, channel 3,
//   degenerate geometry) give coupling 0 with coupling_valid low.
//   Reset empties the pipeline: items in flight are dropped and no done
//   follows for them.
// ----------------------------------------------------------------------------
module karplus_dihedral_coupling (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  kdc_pkg::kdc_req_t req,
  output logic              done,
  output kdc_pkg::kdc_rsp_t result
);
  import kdc_pkg::*;

`include "karplus_dihedral_coupling_macros.svh"

  logic take;
  assign busy = 1'b0;
  assign take = start & ~busy;

  // stage 1: bond vectors
  logic signed [COORD_BITS-1:0] pt [4][3];
  logic                         v1;
  kdc_tag_t                     g1;
  logic signed [DW-1:0]         b1 [3];
  logic signed [DW-1:0]         b2 [3];
  logic signed [DW-1:0]         b3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pt[0][i] = req.point_one[(2-i)*COORD_BITS +: COORD_BITS];
      pt[1][i] = req.point_two[(2-i)*COORD_BITS +: COORD_BITS];
      pt[2][i] = req.point_three[(2-i)*COORD_BITS +: COORD_BITS];
      pt[3][i] = req.point_four[(2-i)*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      b1[i] <= DW'(pt[1][i]) - DW'(pt[0][i]);
      b2[i] <= DW'(pt[2][i]) - DW'(pt[1][i]);
      b3[i] <= DW'(pt[3][i]) - DW'(pt[2][i]);
    end
    g1.ok  <= (req.req_type != REQ_NONE) && req.atoms_present;
    g1.sel <= req.req_type;
    g1.neg <= 1'b0;
    g1.mag <= '0;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  // stage 2: cross product terms
  logic                   v2;
  kdc_tag_t               g2;
  logic signed [2*DW-1:0] pa1 [3];
  logic signed [2*DW-1:0] pb1 [3];
  logic signed [2*DW-1:0] pa2 [3];
  logic signed [2*DW-1:0] pb2 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa1[i] <= b1[(i+1)%3] * b2[(i+2)%3];
      pb1[i] <= b1[(i+2)%3] * b2[(i+1)%3];
      pa2[i] <= b2[(i+1)%3] * b3[(i+2)%3];
      pb2[i] <= b2[(i+2)%3] * b3[(i+1)%3];
    end
    g2.ok  <= g1.ok && ((b2[0] != '0) || (b2[1] != '0) || (b2[2] != '0));
    g2.sel <= g1.sel;
    g2.neg <= g1.neg;
    g2.mag <= g1.mag;
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // stage 3: normals
  logic                 v3;
  kdc_tag_t             g3;
  logic signed [NW-1:0] n1 [3];
  logic signed [NW-1:0] n2 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      n1[i] <= NW'(pa1[i]) - NW'(pb1[i]);
      n2[i] <= NW'(pa2[i]) - NW'(pb2[i]);
    end
    g3 <= g2;
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  // stage 4: magnitudes and signs
  logic          v4;
  kdc_tag_t      g4;
  logic [NW-1:0] m1 [3];
  logic [NW-1:0] m2 [3];
  logic [2:0]    sg1;
  logic [2:0]    sg2;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1[i]  <= n1[i][NW-1] ? NW'(-n1[i]) : NW'(n1[i]);
      m2[i]  <= n2[i][NW-1] ? NW'(-n2[i]) : NW'(n2[i]);
      sg1[i] <= n1[i][NW-1];
      sg2[i] <= n2[i][NW-1];
    end
    g4.ok  <= g3.ok && ((n1[0] != '0) || (n1[1] != '0) || (n1[2] != '0))
                    && ((n2[0] != '0) || (n2[1] != '0) || (n2[2] != '0));
    g4.sel <= g3.sel;
    g4.neg <= g3.neg;
    g4.mag <= g3.mag;
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  // stage 5: leading one of the largest component
  logic          v5;
  kdc_tag_t      g5;
  logic [NW-1:0] m1r [3];
  logic [NW-1:0] m2r [3];
  logic [2:0]    sg1r;
  logic [2:0]    sg2r;
  logic [LW-1:0] ld1;
  logic [LW-1:0] ld2;

  always_ff @(posedge clk) begin
    m1r  <= m1;
    m2r  <= m2;
    sg1r <= sg1;
    sg2r <= sg2;
    ld1  <= lead_pos(m1[0] | m1[1] | m1[2]);
    ld2  <= lead_pos(m2[0] | m2[1] | m2[2]);
    g5   <= g4;
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  // stage 6: normalize, largest component into [2^14, 2^15)
  logic                  v6;
  kdc_tag_t              g6;
  logic signed [NPW-1:0] q1 [3];
  logic signed [NPW-1:0] q2 [3];
  logic [NW-1:0]         sh1 [3];
  logic [NW-1:0]         sh2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ld1 >= LW'(NORM_MSB)) begin
        sh1[i] = m1r[i] >> (ld1 - LW'(NORM_MSB));
      end else begin
        sh1[i] = m1r[i] << (LW'(NORM_MSB) - ld1);
      end
      if (ld2 >= LW'(NORM_MSB)) begin
        sh2[i] = m2r[i] >> (ld2 - LW'(NORM_MSB));
      end else begin
        sh2[i] = m2r[i] << (LW'(NORM_MSB) - ld2);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q1[i] <= sg1r[i] ? -$signed({1'b0, sh1[i][NPW-2:0]}) : $signed({1'b0, sh1[i][NPW-2:0]});
      q2[i] <= sg2r[i] ? -$signed({1'b0, sh2[i][NPW-2:0]}) : $signed({1'b0, sh2[i][NPW-2:0]});
    end
    g6 <= g5;
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
  end

  // stage 7: dot products
  logic                 v7;
  kdc_tag_t             g7;
  logic signed [PW-1:0] dp [3];
  logic signed [PW-1:0] sp1 [3];
  logic signed [PW-1:0] sp2 [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dp[i]  <= q1[i] * q2[i];
      sp1[i] <= q1[i] * q1[i];
      sp2[i] <= q2[i] * q2[i];
    end
    g7 <= g6;
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  // stage 8: sums
  logic                 v8;
  kdc_tag_t             g8;
  logic signed [SW-1:0] dsum;
  logic signed [SW-1:0] s1sum;
  logic signed [SW-1:0] s2sum;

  always_ff @(posedge clk) begin
    dsum  <= SW'(dp[0]) + SW'(dp[1]) + SW'(dp[2]);
    s1sum <= SW'(sp1[0]) + SW'(sp1[1]) + SW'(sp1[2]);
    s2sum <= SW'(sp2[0]) + SW'(sp2[1]) + SW'(sp2[2]);
    g8    <= g7;
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
  end

  // stage 9: product of squared lengths
  logic            v9;
  kdc_tag_t        g9;
  logic [SQ_W-1:0] sq;

  always_ff @(posedge clk) begin
    sq     <= SQ_W'(s1sum[RT_W-1:0]) * SQ_W'(s2sum[RT_W-1:0]);
    g9.ok  <= g8.ok;
    g9.sel <= g8.sel;
    g9.neg <= dsum[SW-1];
    g9.mag <= dsum[SW-1] ? DMAG_W'(-dsum) : DMAG_W'(dsum);
    if (rst) begin
      v9 <= 1'b0;
    end else begin
      v9 <= v8;
    end
  end

  logic            vs;
  kdc_tag_t        gs;
  logic [RT_W-1:0] den;

  kdc_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v9),
    .x         (sq),
    .in_tag    (g9),
    .out_valid (vs),
    .root      (den),
    .out_tag   (gs)
  );

  // stage 10: rounded Q30 numerator
  logic            v10;
  kdc_tag_t        g10;
  logic [SQ_W-1:0] num;
  logic [RT_W-1:0] den_r;

  always_ff @(posedge clk) begin
    num   <= (SQ_W'(gs.mag) << Q30) + SQ_W'(den >> 1);
    den_r <= den;
    g10   <= gs;
    if (rst) begin
      v10 <= 1'b0;
    end else begin
      v10 <= vs;
    end
  end

  logic            vd;
  kdc_tag_t        gd;
  logic [RT_W-1:0] quo;

  kdc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10),
    .num       (num),
    .den       (den_r),
    .in_tag    (g10),
    .out_valid (vd),
    .quo       (quo),
    .out_tag   (gd)
  );

  // stage 11: clamp cosine
  logic                   v11;
  kdc_tag_t               g11;
  logic [CM_W-1:0]        cm;
  logic signed [RT_W-1:0] cs11;
  logic [CM_W-1:0]        cmc;

  always_comb begin
    if (quo > RT_W'(1 << Q30)) begin
      cmc = CM_W'(1 << Q30);
    end else begin
      cmc = quo[CM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cm   <= cmc;
    cs11 <= gd.neg ? -$signed(RT_W'(cmc)) : $signed(RT_W'(cmc));
    g11  <= gd;
    if (rst) begin
      v11 <= 1'b0;
    end else begin
      v11 <= vd;
    end
  end

  // stage 12: square
  logic                   v12;
  kdc_tag_t               g12;
  logic [2*CM_W-1:0]      cc;
  logic signed [RT_W-1:0] cs12;

  always_ff @(posedge clk) begin
    cc   <= (2*CM_W)'(cm) * (2*CM_W)'(cm);
    cs12 <= cs11;
    g12  <= g11;
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
  end

  // stage 13: round square to Q30
  logic                   v13;
  kdc_tag_t               g13;
  logic [CM_W-1:0]        c2;
  logic signed [RT_W-1:0] cs13;
  logic [2*CM_W:0]        ccr;

  assign ccr = (2*CM_W+1)'(cc) + (2*CM_W+1)'(1 << (Q30 - 1));

  always_ff @(posedge clk) begin
    c2   <= ccr[Q30 +: CM_W];
    cs13 <= cs12;
    g13  <= g12;
    if (rst) begin
      v13 <= 1'b0;
    end else begin
      v13 <= v12;
    end
  end

  // stage 14: coefficient products
  logic                   v14;
  kdc_tag_t               g14;
  logic signed [PR_W-1:0] ta;
  logic signed [PR_W-1:0] tb;

  always_ff @(posedge clk) begin
    ta  <= PR_W'(coef_a(g13.sel)) * PR_W'($signed({1'b0, c2}));
    tb  <= PR_W'(coef_b(g13.sel)) * PR_W'(cs13);
    g14 <= g13;
    if (rst) begin
      v14 <= 1'b0;
    end else begin
      v14 <= v13;
    end
  end

  // stage 15: polynomial sum
  logic                 v15;
  kdc_tag_t             g15;
  logic signed [TW-1:0] tsum;

  always_ff @(posedge clk) begin
    tsum <= TW'(ta) + TW'(tb) + (TW'(coef_c(g14.sel)) <<< Q30);
    g15  <= g14;
    if (rst) begin
      v15 <= 1'b0;
    end else begin
      v15 <= v14;
    end
  end

  // stage 16: magnitude, half-step round, drop 2^20
  logic           v16;
  kdc_tag_t       g16;
  logic [U_W-1:0] u16;
  logic [TW:0]    tmag;

  assign tmag = (TW+1)'(tsum[TW-1] ? -tsum : tsum) + (TW+1)'(OUT_HALF);

  always_ff @(posedge clk) begin
    u16     <= tmag[OUT_SHIFT +: U_W];
    g16.ok  <= g15.ok;
    g16.sel <= g15.sel;
    g16.neg <= tsum[TW-1];
    g16.mag <= g15.mag;
    if (rst) begin
      v16 <= 1'b0;
    end else begin
      v16 <= v15;
    end
  end

  // stage 17: reciprocal estimate of u / 100
  logic              v17;
  kdc_tag_t          g17;
  logic [U_W-1:0]    u17;
  logic [JM_W-1:0]   q0;
  logic [U_W+15:0]   rp;

  assign rp = (U_W+16)'(u16) * (U_W+16)'(RECIP);

  always_ff @(posedge clk) begin
    q0  <= rp[RECIP_SH +: JM_W];
    u17 <= u16;
    g17 <= g16;
    if (rst) begin
      v17 <= 1'b0;
    end else begin
      v17 <= v16;
    end
  end

  // output: correct estimate, sign, saturate
  logic [U_W+1:0]  rem;
  logic [JM_W-1:0] jm;
  logic [14:0]     jv;

  always_comb begin
    rem = (U_W+2)'(u17) - (U_W+2)'(q0) * (U_W+2)'(OUT_SCALE);
    jm  = rem[U_W+1] ? q0 - JM_W'(1) : q0;
    if (g17.neg) begin
      if (jm >= JM_W'(J_MIN_MAG)) begin
        jv = 15'(-J_MIN_MAG);
      end else begin
        jv = 15'(-$signed({1'b0, jm}));
      end
    end else begin
      if (jm > JM_W'(J_MAX)) begin
        jv = 15'(J_MAX);
      end else begin
        jv = jm[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.coupling       <= g17.ok ? $signed(jv) : '0;
    result.coupling_valid <= g17.ok;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v17;
    end
  end

  `KDC_ASSERT_IMP(a_latency, take, ##LATENCY done, "result missing after fixed latency")
  `KDC_ASSERT_IMP(a_no_spurious, done, $past(take, LATENCY), "result without transfer")
  `KDC_ASSERT_IMP(a_invalid_zero, done && !result.coupling_valid, result.coupling == '0,
                  "invalid result carries nonzero coupling")
  `KDC_ASSERT_NXT(a_bad_channel, take && req.req_type == REQ_NONE,
                  ##(LATENCY-1) (done && !result.coupling_valid), "channel 3 flagged valid")

endmodule
